>>> src/assert_macros.svh
// Assertion helpers for the checker file scsa_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define AST_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define AST_ALWAYS(lbl, clk, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

>>> src/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared widths, codes and the sequencer state type of the allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int UNIT_W     = 17;
  localparam int SIZE_W     = 32;
  localparam int PORT_OFF_W = 40;
  localparam int REGION_W   = 40;
  localparam int LIMIT_W    = 6;
  localparam int LIM_W      = 9;
  localparam int HEAD_W     = 41;
  localparam int DIVD_W     = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int STAT_W     = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FREE_RD,
    S_ALLOC_RD,
    S_POP,
    S_SEG_RD,
    S_REM_CHK,
    S_REM_DIV,
    S_PUSH_RD,
    S_CARVE,
    S_FIN
  } seq_state_t;

endpackage

>>> src/scsa_if.sv
// ----------------------------------------------------------------------------
// scsa_if
// Valid/ready channels: request, result and register write.
// ----------------------------------------------------------------------------
interface scsa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [scsa_pkg::SIZE_W-1:0]     size_bytes;
  logic [scsa_pkg::PORT_OFF_W-1:0] block_offset;
  modport source (output valid, operation, size_bytes, block_offset, input ready);
  modport sink (input valid, operation, size_bytes, block_offset, output ready);
endinterface

interface scsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [scsa_pkg::STAT_W-1:0]     status;
  logic [scsa_pkg::PORT_OFF_W-1:0] granted_offset;
  logic [scsa_pkg::SIZE_W-1:0]     granted_bytes;
  modport source (output valid, status, granted_offset, granted_bytes, input ready);
  modport sink (input valid, status, granted_offset, granted_bytes, output ready);
endinterface

interface scsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [scsa_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [scsa_pkg::CFG_DATA_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> src/size_class_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_segment_allocator_top
// Size-class allocator over a byte region, with per-class segments and
// per-class free stacks held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request words (operation, size_bytes, block_offset).
//   out_ch : one result word per request (status, granted_offset, bytes).
//   cfg_ch : register writes, always ready; write only while idle.
// One request at a time. Each request first runs through the bit-serial
// divider. A bad size or a class too large then goes straight to the
// result; a free or an allocate hit takes one table read, a pop a stack
// read after it, and each further class walked one more table read. A new
// segment with an old remainder takes a second divider pass, then a push.
// The block is ready for the next request in the cycle the result word
// goes valid.
// A finished result sits in the output register; the next request is
// accepted while it waits. A stalled receiver holds the result word; the
// result after it then waits in the sequencer, which takes no request
// meanwhile.
// Reset clears the class table valid bits and the region head and sets
// the registers to their defaults; the stack store needs no clearing.
// ----------------------------------------------------------------------------
module size_class_segment_allocator_top #(
  parameter int NUM_CLASSES = 32,
  parameter int STACK_DEPTH = 1024,
  parameter int OFFSET_BITS = 40
) (
  input  logic clk,
  input  logic rst_n,
  scsa_req_if.sink   in_ch,
  scsa_rsp_if.source out_ch,
  scsa_cfg_if.sink   cfg_ch
);
  import scsa_pkg::*;

  localparam int CW   = $clog2(NUM_CLASSES);
  localparam int NW   = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(NUM_CLASSES * STACK_DEPTH);
  localparam int OB   = OFFSET_BITS;
  localparam int EW   = NW + OB + SIZE_W;

  // configuration registers
  logic [UNIT_W-1:0]   unit_r;
  logic [SIZE_W-1:0]   seg_r;
  logic [REGION_W-1:0] region_r;
  logic [LIMIT_W-1:0]  climit_r;

  // sequencer and request context
  seq_state_t          state_r, state_nxt;
  logic                op_r;
  logic [SIZE_W-1:0]   size_r;
  logic [OB-1:0]       offset_r;
  logic [DIVD_W-1:0]   dvd_r, dvd_nxt;
  logic [SIZE_W-1:0]   aligned_r, aligned_nxt;
  logic [CW-1:0]       b_r, b_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       q_r, q_nxt;
  logic [HEAD_W-1:0]   head_r, head_nxt;
  logic [OB-1:0]       seg_off_r, seg_off_nxt;
  logic [OB-1:0]       old_cur_r, old_cur_nxt;
  logic [SIZE_W-1:0]   old_rem_r, old_rem_nxt;
  logic [NW-1:0]       old_cnt_r, old_cnt_nxt;
  logic [STAT_W-1:0]   res_st_r, res_st_nxt;
  logic [OB-1:0]       res_off_r, res_off_nxt;
  logic [SIZE_W-1:0]   res_bytes_r, res_bytes_nxt;

  // result register
  logic                out_vld_r, out_vld_nxt;
  logic [STAT_W-1:0]   out_st_r;
  logic [OB-1:0]       out_off_r;
  logic [SIZE_W-1:0]   out_bytes_r;

  // derived values
  logic [UNIT_W-1:0]   unit_eff;
  logic [LIM_W-1:0]    lim;
  logic [DIVD_W-1:0]   lim_d;
  logic                accept;
  logic                slot_free;

  // divider
  logic                div_start;
  logic [DIVD_W-1:0]   div_dvd;
  logic                div_done;
  logic [DIVD_W-1:0]   div_q;
  logic [UNIT_W-1:0]   div_r;
  logic [DIVD_W-1:0]   aligned_full;

  // class table
  logic                tab_rd_en, tab_wr_en;
  logic [CW-1:0]       tab_rd_addr, tab_wr_addr;
  logic [EW-1:0]       tab_rd_data, tab_wr_data;
  logic [NW-1:0]       tab_cnt;
  logic [OB-1:0]       tab_cur;
  logic [SIZE_W-1:0]   tab_rem;

  // stack store
  logic                stk_rd_en, stk_wr_en;
  logic [SA_W-1:0]     stk_rd_addr, stk_wr_addr;
  logic [OB-1:0]       stk_rd_data, stk_wr_data;

  // decisions
  logic                free_bad, alloc_bad, alloc_big;
  logic                hit, can_pop, stk_room, head_ok, seg_fit, more_cls, rem_ok;
  logic [HEAD_W:0]     seg_end;
  logic [LIM_W-1:0]    i_inc;

  function automatic logic [SA_W-1:0] stk_addr(logic [CW-1:0] cls, logic [NW-1:0] ptr);
    stk_addr = SA_W'(SA_W'(cls) * SA_W'(STACK_DEPTH) + SA_W'(ptr));
  endfunction

  assign unit_eff  = (unit_r == '0) ? UNIT_W'(1) : unit_r;
  assign lim       = (LIM_W'(climit_r) < LIM_W'(NUM_CLASSES)) ? LIM_W'(climit_r)
                                                             : LIM_W'(NUM_CLASSES);
  assign lim_d     = DIVD_W'(lim);
  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_vld_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign {tab_cnt, tab_cur, tab_rem} = tab_rd_data;

  assign aligned_full = dvd_r - DIVD_W'(div_r);
  assign free_bad  = (size_r == '0) || (div_r != '0) || (div_q >= lim_d);
  assign alloc_bad = (aligned_full == '0) || (aligned_full > DIVD_W'(seg_r));
  assign alloc_big = div_q >= lim_d;
  assign hit       = tab_rem >= aligned_r;
  assign can_pop   = tab_cnt != '0;
  assign stk_room  = tab_cnt < NW'(STACK_DEPTH);
  assign head_ok   = head_r < HEAD_W'(region_r);
  assign seg_end   = (HEAD_W+1)'(head_r) + (HEAD_W+1)'(seg_r);
  assign seg_fit   = seg_end <= (HEAD_W+1)'(region_r);
  assign i_inc     = LIM_W'(i_r) + LIM_W'(1);
  assign more_cls  = i_inc < lim;
  assign rem_ok    = (div_r == '0) && (div_q < lim_d);

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (accept) state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (op_r == OP_FREE) state_nxt = free_bad ? S_FIN : S_FREE_RD;
          else if (alloc_bad || alloc_big) state_nxt = S_FIN;
          else state_nxt = S_ALLOC_RD;
        end
      end
      S_FREE_RD: state_nxt = S_FIN;
      S_ALLOC_RD: begin
        if (hit) state_nxt = S_FIN;
        else if (can_pop) state_nxt = S_POP;
        else if (head_ok && seg_fit) state_nxt = (i_r == b_r) ? S_REM_CHK : S_SEG_RD;
        else if (!more_cls) state_nxt = S_FIN;
      end
      S_POP:     state_nxt = S_FIN;
      S_SEG_RD:  state_nxt = S_REM_CHK;
      S_REM_CHK: state_nxt = (old_rem_r == '0) ? S_CARVE : S_REM_DIV;
      S_REM_DIV: if (div_done) state_nxt = rem_ok ? S_PUSH_RD : S_CARVE;
      S_PUSH_RD: state_nxt = S_CARVE;
      S_CARVE:   state_nxt = S_FIN;
      S_FIN:     if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    dvd_nxt       = dvd_r;
    aligned_nxt   = aligned_r;
    b_nxt         = b_r;
    i_nxt         = i_r;
    q_nxt         = q_r;
    head_nxt      = head_r;
    seg_off_nxt   = seg_off_r;
    old_cur_nxt   = old_cur_r;
    old_rem_nxt   = old_rem_r;
    old_cnt_nxt   = old_cnt_r;
    res_st_nxt    = res_st_r;
    res_off_nxt   = res_off_r;
    res_bytes_nxt = res_bytes_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    div_start     = 1'b0;
    div_dvd       = DIVD_W'(in_ch.size_bytes);
    tab_rd_en     = 1'b0;
    tab_rd_addr   = i_r;
    tab_wr_en     = 1'b0;
    tab_wr_addr   = i_r;
    tab_wr_data   = tab_rd_data;
    stk_rd_en     = 1'b0;
    stk_rd_addr   = stk_addr(i_r, tab_cnt - NW'(1));
    stk_wr_en     = 1'b0;
    stk_wr_addr   = stk_addr(b_r, tab_cnt);
    stk_wr_data   = offset_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // rounding up for allocate: divide size + unit - 1
          if (in_ch.operation == OP_FREE) div_dvd = DIVD_W'(in_ch.size_bytes);
          else div_dvd = DIVD_W'(in_ch.size_bytes) + DIVD_W'(unit_eff) - DIVD_W'(1);
          div_start = 1'b1;
          dvd_nxt   = div_dvd;
        end
      end
      S_DIV: begin
        if (div_done) begin
          b_nxt         = div_q[CW-1:0];
          i_nxt         = div_q[CW-1:0];
          aligned_nxt   = aligned_full[SIZE_W-1:0];
          res_off_nxt   = '0;
          res_bytes_nxt = '0;
          if (op_r == OP_FREE) begin
            res_st_nxt = ST_BAD_SIZE;
            if (!free_bad) begin
              tab_rd_en   = 1'b1;
              tab_rd_addr = div_q[CW-1:0];
            end
          end else if (alloc_bad) begin
            res_st_nxt = ST_BAD_SIZE;
          end else if (alloc_big) begin
            res_st_nxt = ST_NO_SPACE;
          end else begin
            tab_rd_en   = 1'b1;
            tab_rd_addr = div_q[CW-1:0];
          end
        end
      end
      S_FREE_RD: begin
        // push the freed offset, or drop it on a full stack
        tab_wr_addr = b_r;
        if (stk_room) begin
          stk_wr_en   = 1'b1;
          tab_wr_en   = 1'b1;
          tab_wr_data = {tab_cnt + NW'(1), tab_cur, tab_rem};
          res_st_nxt  = ST_OK;
        end else begin
          res_st_nxt  = ST_DROPPED;
        end
      end
      S_ALLOC_RD: begin
        if (hit) begin
          // carve from the current segment of this class
          tab_wr_en     = 1'b1;
          tab_wr_data   = {tab_cnt, OB'(tab_cur + OB'(aligned_r)), tab_rem - aligned_r};
          res_st_nxt    = ST_OK;
          res_off_nxt   = tab_cur;
          res_bytes_nxt = aligned_r;
        end else if (can_pop) begin
          tab_wr_en   = 1'b1;
          tab_wr_data = {tab_cnt - NW'(1), tab_cur, tab_rem};
          stk_rd_en   = 1'b1;
        end else begin
          if (head_ok) head_nxt = HEAD_W'(seg_end);
          if (head_ok && seg_fit) begin
            seg_off_nxt = OB'(head_r);
            old_cur_nxt = tab_cur;
            old_rem_nxt = tab_rem;
            old_cnt_nxt = tab_cnt;
            if (i_r != b_r) begin
              tab_rd_en   = 1'b1;
              tab_rd_addr = b_r;
            end
          end else if (more_cls) begin
            // advance to the next class
            i_nxt       = i_inc[CW-1:0];
            tab_rd_en   = 1'b1;
            tab_rd_addr = i_inc[CW-1:0];
          end else begin
            res_st_nxt = ST_NO_SPACE;
          end
        end
      end
      S_POP: begin
        res_st_nxt    = ST_OK;
        res_off_nxt   = stk_rd_data;
        res_bytes_nxt = SIZE_W'(i_r) * SIZE_W'(unit_eff);
      end
      S_SEG_RD: begin
        old_cur_nxt = tab_cur;
        old_rem_nxt = tab_rem;
        old_cnt_nxt = tab_cnt;
      end
      S_REM_CHK: begin
        if (old_rem_r != '0) begin
          div_start = 1'b1;
          div_dvd   = DIVD_W'(old_rem_r);
        end
      end
      S_REM_DIV: begin
        if (div_done && rem_ok) begin
          q_nxt       = div_q[CW-1:0];
          tab_rd_en   = 1'b1;
          tab_rd_addr = div_q[CW-1:0];
        end
      end
      S_PUSH_RD: begin
        // old remainder onto the stack of its class; drop on a full stack
        if (stk_room) begin
          stk_wr_en   = 1'b1;
          stk_wr_addr = stk_addr(q_r, tab_cnt);
          stk_wr_data = old_cur_r;
          tab_wr_en   = 1'b1;
          tab_wr_addr = q_r;
          tab_wr_data = {tab_cnt + NW'(1), tab_cur, tab_rem};
        end
      end
      S_CARVE: begin
        tab_wr_en     = 1'b1;
        tab_wr_addr   = b_r;
        tab_wr_data   = {old_cnt_r, OB'(seg_off_r + OB'(aligned_r)), seg_r - aligned_r};
        res_st_nxt    = ST_OK;
        res_off_nxt   = seg_off_r;
        res_bytes_nxt = aligned_r;
      end
      S_FIN: begin
        if (slot_free) out_vld_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      head_r    <= '0;
      unit_r    <= UNIT_W'(64);
      seg_r     <= SIZE_W'(2097152);
      region_r  <= '0;
      climit_r  <= LIMIT_W'(32);
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      head_r    <= head_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_UNIT:    unit_r   <= cfg_ch.wr_data[UNIT_W-1:0];
          CFG_SEGMENT: seg_r    <= cfg_ch.wr_data[SIZE_W-1:0];
          CFG_REGION:  region_r <= cfg_ch.wr_data[REGION_W-1:0];
          CFG_LIMIT:   climit_r <= cfg_ch.wr_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.operation;
      size_r   <= in_ch.size_bytes;
      offset_r <= OB'(in_ch.block_offset);
    end
    dvd_r       <= dvd_nxt;
    aligned_r   <= aligned_nxt;
    b_r         <= b_nxt;
    i_r         <= i_nxt;
    q_r         <= q_nxt;
    seg_off_r   <= seg_off_nxt;
    old_cur_r   <= old_cur_nxt;
    old_rem_r   <= old_rem_nxt;
    old_cnt_r   <= old_cnt_nxt;
    res_st_r    <= res_st_nxt;
    res_off_r   <= res_off_nxt;
    res_bytes_r <= res_bytes_nxt;
    if (state_r == S_FIN && slot_free) begin
      out_st_r    <= res_st_r;
      out_off_r   <= (res_st_r == ST_OK) ? res_off_r : '0;
      out_bytes_r <= (res_st_r == ST_OK) ? res_bytes_r : '0;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.granted_offset = PORT_OFF_W'(out_off_r);
  assign out_ch.granted_bytes  = out_bytes_r;

  scsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (unit_eff),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  scsa_ctab #(
    .NUM_ENTRIES (NUM_CLASSES),
    .DATA_W      (EW)
  ) u_ctab (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tab_rd_en),
    .rd_addr (tab_rd_addr),
    .rd_data (tab_rd_data),
    .wr_en   (tab_wr_en),
    .wr_addr (tab_wr_addr),
    .wr_data (tab_wr_data)
  );

  scsa_stk #(
    .DEPTH  (NUM_CLASSES * STACK_DEPTH),
    .DATA_W (OB)
  ) u_stk (
    .clk     (clk),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data)
  );

endmodule

>>> src/scsa_div.sv
// ----------------------------------------------------------------------------
// scsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scsa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scsa_pkg::DIVD_W-1:0] dividend,
  input  logic [scsa_pkg::UNIT_W-1:0] divisor,
  output logic                        done,
  output logic [scsa_pkg::DIVD_W-1:0] quo,
  output logic [scsa_pkg::UNIT_W-1:0] rem
);
  import scsa_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [UNIT_W-1:0] rem_r;
  logic [UNIT_W-1:0] dvs_r;
  logic [UNIT_W:0]   shifted;
  logic [UNIT_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= ge ? diff[UNIT_W-1:0] : shifted[UNIT_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> src/scsa_ctab.sv
// ----------------------------------------------------------------------------
// scsa_ctab
// Per-class table (stack count, segment cursor, segment remainder).
// Entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module scsa_ctab #(
  parameter int NUM_ENTRIES = 32,
  parameter int DATA_W      = 83
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
  output logic [DATA_W-1:0]              rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
  input  logic [DATA_W-1:0]              wr_data
);
  import scsa_pkg::*;

  logic [DATA_W-1:0] mem [NUM_ENTRIES];
  logic              vld_r [NUM_ENTRIES];
  logic [DATA_W-1:0] data_r;
  logic              data_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_ENTRIES; k++) vld_r[k] <= 1'b0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      data_r     <= mem[rd_addr];
      data_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = data_vld_r ? data_r : '0;

endmodule

>>> src/scsa_stk.sv
// ----------------------------------------------------------------------------
// scsa_stk
// Free stack store, all classes in one memory, registered read.
// ----------------------------------------------------------------------------
module scsa_stk #(
  parameter int DEPTH  = 32768,
  parameter int DATA_W = 40
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);
  import scsa_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) data_r <= mem[rd_addr];
  end

  assign rd_data = data_r;

endmodule

>>> src/scsa_chk.sv
// ----------------------------------------------------------------------------
// scsa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scsa_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [scsa_pkg::STAT_W-1:0]     status,
  input logic [scsa_pkg::PORT_OFF_W-1:0] granted_offset,
  input logic [scsa_pkg::SIZE_W-1:0]     granted_bytes
);
  import scsa_pkg::*;

  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_offset) && $stable(granted_bytes), "stalled result changed")
  `AST_IMPL(a_fail_zero, clk, rst_n, out_valid && (status != ST_OK), (granted_offset == '0) && (granted_bytes == '0), "failed result carries a grant")
  `AST_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")
  `AST_NEXT(a_one_at_time, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind size_class_segment_allocator_top scsa_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .granted_offset (out_ch.granted_offset),
  .granted_bytes  (out_ch.granted_bytes)
);

>>> verif/size_class_segment_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// size_class_segment_allocator_top_tb
// Self-checking bench for the size-class allocator: directed requests on the
// reset values, register extremes, segment bound and free stack reuse, then
// random allocate/free traffic under several register settings, all checked
// word by word against a predictor of the allocator's class tables.
// ----------------------------------------------------------------------------
module size_class_segment_allocator_top_tb;
  import scsa_pkg::*;

  localparam int NCLS  = 32;
  localparam int DEPTH = 1024;
  localparam longint unsigned OFF_MASK  = (64'd1 << 40) - 1;
  localparam longint unsigned HEAD_MASK = (64'd1 << 41) - 1;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [PORT_OFF_W-1:0] offset;
    logic [SIZE_W-1:0]     bytes;
  } grant_t;

  logic clk;
  logic rst_n;

  scsa_req_if in_ch();
  scsa_rsp_if out_ch();
  scsa_cfg_if cfg_ch();

  size_class_segment_allocator_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the allocator: registers, class tables and free stacks.
  longint unsigned  sh_unit, sh_segment, sh_region, sh_limit;
  logic [39:0]      stk_mem [NCLS][DEPTH];
  int unsigned      stk_cnt [NCLS];
  longint unsigned  seg_cur [NCLS];
  longint unsigned  seg_rem [NCLS];
  longint unsigned  region_head;

  grant_t grant_q[$];
  int     fail_cnt;
  int     rsp_seen;
  bit     idle_on;
  int     stall_left;
  int     hold_left;
  bit     hold_done;

  function automatic longint unsigned unit_eff();
    return (sh_unit == 0) ? 64'd1 : sh_unit;
  endfunction

  function automatic longint unsigned limit_eff();
    return (sh_limit < NCLS) ? sh_limit : NCLS;
  endfunction

  function automatic bit stack_push(longint unsigned cls, longint unsigned off);
    if (cls >= NCLS || stk_cnt[cls] >= DEPTH) return 1'b0;
    stk_mem[cls][stk_cnt[cls]] = off[39:0];
    stk_cnt[cls]++;
    return 1'b1;
  endfunction

  // Replace the segment of class b with a fresh one from the region head.
  function automatic bit new_segment(longint unsigned b);
    longint unsigned off;
    longint unsigned u;
    longint unsigned r;
    off = region_head;
    u   = unit_eff();
    if (off >= sh_region) return 1'b0;
    // head moves even when the segment is then refused
    region_head = (off + sh_segment) & HEAD_MASK;
    if (off + sh_segment > sh_region) return 1'b0;
    r = seg_rem[b];
    if (r > 0 && r % u == 0 && r / u < limit_eff())
      void'(stack_push(r / u, seg_cur[b]));
    seg_cur[b] = off & OFF_MASK;
    seg_rem[b] = sh_segment;
    return 1'b1;
  endfunction

  function automatic grant_t grant_for(logic op, logic [31:0] sz, logic [39:0] boff);
    grant_t          g;
    longint unsigned u, lim, cls, b, aligned, i, size;
    bit              done, carve;
    u    = unit_eff();
    lim  = limit_eff();
    size = sz;
    g    = '0;
    g.status = ST_NO_SPACE;
    if (op == OP_FREE) begin
      cls = size / u;
      if (size == 0 || size % u != 0 || cls >= lim) g.status = ST_BAD_SIZE;
      else if (stack_push(cls, boff)) g.status = ST_OK;
      else g.status = ST_DROPPED;
    end else begin
      b       = (size + u - 1) / u;
      aligned = b * u;
      if (aligned == 0 || aligned > sh_segment) begin
        g.status = ST_BAD_SIZE;
      end else begin
        i    = b;
        done = 1'b0;
        while (!done && i < lim) begin
          carve = 1'b0;
          if (seg_rem[i] >= aligned) begin
            carve = 1'b1;
          end else if (stk_cnt[i] > 0) begin
            stk_cnt[i]--;
            g.offset = stk_mem[i][stk_cnt[i]];
            g.bytes  = i * u;
            g.status = ST_OK;
            done     = 1'b1;
          end else if (new_segment(b)) begin
            i     = b;
            carve = 1'b1;
          end
          if (carve) begin
            g.offset   = seg_cur[i];
            g.bytes    = aligned;
            seg_rem[i] = seg_rem[i] - aligned;
            seg_cur[i] = (seg_cur[i] + aligned) & OFF_MASK;
            g.status   = ST_OK;
            done       = 1'b1;
          end else if (!done) begin
            i++;
          end
        end
      end
    end
    if (g.status != ST_OK) begin
      g.offset = '0;
      g.bytes  = '0;
    end
    return g;
  endfunction

  // Send one request word; valid stays high so the next word follows at once, unless a random idle gap comes first.
  task automatic send_req(logic op, logic [31:0] sz, logic [39:0] boff);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.size_bytes   <= sz;
    in_ch.block_offset <= boff;
    do @(posedge clk); while (!in_ch.ready);
    grant_q.push_back(grant_for(op, sz, boff));
  endtask

  // Drain the block, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned data);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data[39:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_UNIT:    sh_unit    = data & 64'h1FFFF;
      CFG_SEGMENT: sh_segment = data & 64'hFFFF_FFFF;
      CFG_REGION:  sh_region  = data & OFF_MASK;
      CFG_LIMIT:   sh_limit   = data & 64'h3F;
      default: begin
      end
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(longint unsigned u, longint unsigned s, longint unsigned r,
                          longint unsigned l);
    write_reg(CFG_UNIT, u);
    write_reg(CFG_SEGMENT, s);
    write_reg(CFG_REGION, r);
    write_reg(CFG_LIMIT, l);
  endtask

  function automatic logic [39:0] rand_off();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[39:0];
  endfunction

  // Result checker.
  always @(posedge clk) begin
    grant_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        rsp_seen++;
        if (grant_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result word status=%0d", out_ch.status);
        end else begin
          e = grant_q.pop_front();
          if (out_ch.status !== e.status || out_ch.granted_offset !== e.offset ||
              out_ch.granted_bytes !== e.bytes) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp st=%0d off=%h bytes=%0d got st=%0d off=%h bytes=%0d",
                       e.status, e.offset, e.bytes, out_ch.status,
                       out_ch.granted_offset, out_ch.granted_bytes);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block fills up
  // and back-pressures its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (!hold_done && rsp_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Reset values: region empty, so only bad sizes, frees and pops work.
  task automatic test_reset_state();
    send_req(OP_ALLOC, 32'd64, '0);
    send_req(OP_ALLOC, 32'd0, '0);
    send_req(OP_ALLOC, 32'hFFFF_FFFF, rand_off());
    send_req(OP_FREE, 32'd64, 40'hFF_FFFF_FFFF);
    send_req(OP_FREE, 32'd65, rand_off());
    send_req(OP_FREE, 32'd0, rand_off());
    send_req(OP_FREE, 32'd64 * 32, rand_off());
    send_req(OP_ALLOC, 32'd1, '0);
  endtask

  // Walk into the region bound; remainder of an old segment goes to class 2.
  task automatic test_segment_bound();
    set_regs(64, 4096, 10000, 32);
    repeat (5) send_req(OP_ALLOC, 32'd1984, '0);
    send_req(OP_ALLOC, 32'd128, '0);
    send_req(OP_ALLOC, 32'd2048, '0);
    send_req(OP_ALLOC, 32'd4097, '0);
  endtask

  task automatic test_config_extremes();
    set_regs(0, 100, 1000, 2);
    send_req(OP_ALLOC, 32'd1, '0);
    send_req(OP_ALLOC, 32'd2, '0);
    send_req(OP_FREE, 32'd1, 40'hFF_FFFF_FFFF);
    send_req(OP_ALLOC, 32'd101, '0);
    set_regs(65536, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 63);
    send_req(OP_ALLOC, 32'd1, '0);
    send_req(OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_req(OP_ALLOC, 32'd31 * 65536, '0);
    send_req(OP_FREE, 32'd65536 * 5, rand_off());
    set_regs(8, 1, 64, 2);
    send_req(OP_ALLOC, 32'd1, '0);
  endtask

  // Push a run of freed words onto one class, then pop the newest back.
  task automatic test_stack_reuse();
    set_regs(64, 4096, 0, 32);
    repeat (12) send_req(OP_FREE, 32'd64, rand_off());
    repeat (3) send_req(OP_ALLOC, 32'd64, '0);
  endtask

  task automatic test_random_mix(int n);
    longint unsigned u, lim, c, sz;
    logic            op;
    repeat (n) begin
      u   = unit_eff();
      lim = limit_eff();
      op  = ($urandom_range(0, 9) < 6) ? OP_ALLOC : OP_FREE;
      c   = $urandom_range(0, lim + 1);
      if ($urandom_range(0, 15) == 0) sz = $urandom;
      else if (op == OP_ALLOC) sz = (c * u > u - 1) ? c * u - $urandom_range(0, u - 1) : 0;
      else sz = c * u + (($urandom_range(0, 9) == 0) ? 1 : 0);
      send_req(op, sz[31:0], rand_off());
    end
  endtask

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_ALLOC;
    in_ch.size_bytes   <= '0;
    in_ch.block_offset <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.reg_index   <= CFG_UNIT;
    cfg_ch.wr_data     <= '0;
    fail_cnt   = 0;
    rsp_seen   = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    idle_on    = 1'b1;
    sh_unit    = 64;
    sh_segment = 2097152;
    sh_region  = 0;
    sh_limit   = 32;
    region_head = 0;
    for (int k = 0; k < NCLS; k++) begin
      stk_cnt[k] = 0;
      seg_cur[k] = 0;
      seg_rem[k] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_segment_bound();
    test_config_extremes();
    test_stack_reuse();
    set_regs(64, 4096, 1 << 20, 32);
    test_random_mix(90);
    set_regs(16, 1000, 50000, 8);
    test_random_mix(80);
    set_regs(0, 37, 3000, 40);
    test_random_mix(80);
    set_regs(8, 256, 40'hFF_FFFF_FFFF, 2);
    test_random_mix(60);
    set_regs(64, 8192, 1 << 22, 16);
    idle_on = 1'b0;
    test_random_mix(100);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && grant_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/scsa_pkg.sv
src/scsa_if.sv
src/scsa_div.sv
src/scsa_ctab.sv
src/scsa_stk.sv
src/size_class_segment_allocator_top.sv
src/scsa_chk.sv
verif/size_class_segment_allocator_top_tb.sv
